/* src/rxaf_pkg.sv */
// Shared types and constants for the receive frame address filter.
// No dependencies.
package rxaf_pkg;

    // Parser phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_DROP
    } rxaf_phase_t;

    // Configuration register indexes
    localparam logic [7:0] CFG_OWN_ADDR   = 8'd0;
    localparam logic [7:0] CFG_BCAST_ADDR = 8'd1;

    // Header bytes per frame: destination, source, id, flags
    localparam logic [7:0] HDR_COUNT = 8'd4;

    // Header byte positions
    localparam logic [1:0] HDR_DEST  = 2'd0;
    localparam logic [1:0] HDR_SRC   = 2'd1;
    localparam logic [1:0] HDR_ID    = 2'd2;
    localparam logic [1:0] HDR_FLAGS = 2'd3;

    // Reset values of the address registers
    localparam logic [7:0] OWN_ADDR_RST   = 8'h00;
    localparam logic [7:0] BCAST_ADDR_RST = 8'hFF;

    // One result beat
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] source_address;
        logic [7:0] header_id;
        logic [7:0] header_flags;
        logic       last_byte;
    } rxaf_result_t;

endpackage

/* src/rxaf_parser.sv */
// Frame parser: length check, destination filter, header capture, payload tagging.
// Depends on rxaf_pkg.
module rxaf_parser #(
    parameter int MAX_FRAME_LEN = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  beat_en,
    input  logic [7:0]            rx_byte,
    input  logic                  frame_start,
    input  logic [7:0]            own_addr,
    input  logic [7:0]            bcast_addr,
    output logic                  res_valid,
    output rxaf_pkg::rxaf_result_t res
);
    import rxaf_pkg::*;

    localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

    rxaf_phase_t phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  hidx_reg, hidx_next;
    logic [7:0]  src_reg, src_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  left_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= 8'd0;
            hidx_reg  <= HDR_DEST;
            src_reg   <= 8'd0;
            id_reg    <= 8'd0;
            flags_reg <= 8'd0;
        end
        else if (beat_en)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            hidx_reg  <= hidx_next;
            src_reg   <= src_next;
            id_reg    <= id_next;
            flags_reg <= flags_next;
        end
    end

    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        hidx_next  = hidx_reg;
        src_next   = src_reg;
        id_next    = id_reg;
        flags_next = flags_reg;
        res_valid  = 1'b0;

        res.payload_byte   = rx_byte;
        res.source_address = src_reg;
        res.header_id      = id_reg;
        res.header_flags   = flags_reg;
        res.last_byte      = (left_dec == 8'd0);

        if (frame_start)
        begin
            // length byte; a start inside a frame abandons it
            hidx_next = HDR_DEST;
            left_next = rx_byte;
            if (rx_byte >= HDR_COUNT && rx_byte <= MaxLen)
                phase_next = PH_HEADER;
            else
                phase_next = PH_DROP;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hidx_reg == HDR_DEST && rx_byte != own_addr && rx_byte != bcast_addr)
                    begin
                        phase_next = PH_DROP;
                    end
                    else
                    begin
                        unique case (hidx_reg)
                            HDR_DEST:  ;
                            HDR_SRC:   src_next   = rx_byte;
                            HDR_ID:    id_next    = rx_byte;
                            HDR_FLAGS: flags_next = rx_byte;
                        endcase
                        left_next = left_dec;
                        if (hidx_reg == HDR_FLAGS)
                        begin
                            hidx_next  = HDR_DEST;
                            phase_next = (left_dec == 8'd0) ? PH_IDLE : PH_PAYLOAD;
                        end
                        else
                        begin
                            hidx_next = hidx_reg + 2'd1;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid = 1'b1;
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                        phase_next = PH_IDLE;
                end
                PH_IDLE, PH_DROP: ;
            endcase
        end
    end

endmodule

/* src/rxaf_out_reg.sv */
// Result register between the parser and the output channel.
// Depends on rxaf_pkg.
module rxaf_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  rxaf_pkg::rxaf_result_t res,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   can_take,
    output rxaf_pkg::rxaf_result_t out_res
);
    import rxaf_pkg::*;

    logic         valid_reg, valid_next;
    rxaf_result_t data_reg;

    // slot is free when empty or being drained this cycle
    assign can_take   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

/* src/radio_rx_frame_address_filter.sv */
// Top level of the receive frame deframer with destination address filter.
// Depends on rxaf_pkg, rxaf_parser and rxaf_out_reg.
//
// Usage:
//   Input channel (in_valid/in_ready): one receive FIFO byte per beat, rx_byte,
//   with frame_start high on the length byte that opens a frame.
//   Output channel (out_valid/out_ready): one payload byte per beat of an
//   accepted frame, with the captured source, id and flags headers and
//   last_byte high on the final payload byte.
//   Config channel (cfg_valid/cfg_ready): cfg_index 0 writes own_address,
//   1 writes broadcast_address; other indexes are ignored. Always ready.
// A payload byte shows on the output in the cycle after its input beat.
// Throughput: one byte per cycle while the output is not stalled; the only storage between the two sides is
//   the single result register, so in_ready = !out_valid || out_ready.
// Stall: while the receiver holds out_ready low with a result waiting, the
//   input stalls; bytes that produce no result still wait for the slot.
// Reset: parser goes idle (waits for a frame start), headers clear,
//   own_address = 0, broadcast_address = 255, output register empty.
// Frames with length outside 4..MAX_FRAME_LEN or a foreign destination are
//   dropped until the next frame start; a length-4 frame emits nothing.
module radio_rx_frame_address_filter #(
    parameter int MAX_FRAME_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    // input byte stream
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    // payload output
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic [7:0] source_address,
    output logic [7:0] header_id,
    output logic [7:0] header_flags,
    output logic       last_byte,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import rxaf_pkg::*;

    logic [7:0]   own_addr_q;
    logic [7:0]   bcast_addr_q;
    logic         beat_en;
    logic         res_valid;
    logic         can_take;
    rxaf_result_t res;
    rxaf_result_t out_res;

    // address registers; the user writes only while idle (not enforced), so no hazard handling
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_q   <= OWN_ADDR_RST;
            bcast_addr_q <= BCAST_ADDR_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_OWN_ADDR)
                own_addr_q <= cfg_data;
            else if (cfg_index == CFG_BCAST_ADDR)
                bcast_addr_q <= cfg_data;
        end
    end

    // a byte is taken whenever the result slot can absorb it
    assign in_ready = can_take;
    assign beat_en  = in_valid && can_take;

    rxaf_parser #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_en     (beat_en),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .own_addr    (own_addr_q),
        .bcast_addr  (bcast_addr_q),
        .res_valid   (res_valid),
        .res         (res)
    );

    rxaf_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (beat_en && res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_take  (can_take),
        .out_res   (out_res)
    );

    assign payload_byte   = out_res.payload_byte;
    assign source_address = out_res.source_address;
    assign header_id      = out_res.header_id;
    assign header_flags   = out_res.header_flags;
    assign last_byte      = out_res.last_byte;

endmodule
